// File: sv/trimmed_mean_window_filter_macros.svh
// ----------------------------------------------------------------------------
// Trimmed-mean window filter assertion macros
// Shared helpers that bind concurrent checks to the block clock and reset.
// ----------------------------------------------------------------------------
`ifndef TRIMMED_MEAN_WINDOW_FILTER_MACROS_SVH
`define TRIMMED_MEAN_WINDOW_FILTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TMWF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TMWF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/tmwf_pkg.sv
// ----------------------------------------------------------------------------
// Trimmed-mean window filter package
// Sizes, sequencer states and interface structs shared by the filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tmwf_pkg;

  // Window geometry and derived widths.
  localparam int WINDOW_LEN = 9;
  localparam int SAMPLE_W   = 24;
  localparam int IDX_W      = $clog2(WINDOW_LEN);
  localparam int CNT_W      = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW_LEN);

  // The divider retires two quotient bits per step.
  localparam int DIV_W      = SUM_W + (SUM_W % 2);
  localparam int DIV_STEPS  = DIV_W / 2;
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TRIM,
    ST_START,
    ST_DIV,
    ST_OUT
  } state_e;

  // Write command into the sample ring.
  typedef struct packed {
    logic                       fill;
    logic                       push;
    logic signed [SAMPLE_W-1:0] data;
  } win_cmd_t;

  // Request into the divider.
  typedef struct packed {
    logic                       start;
    logic signed [SUM_W-1:0]    dividend;
    logic        [CNT_W-1:0]    divisor;
  } div_req_t;

endpackage

`default_nettype wire

// File: sv/tmwf_window.sv
// ----------------------------------------------------------------------------
// Sample ring
// Holds the window entries and the write slot, with one indexed read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tmwf_window (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire tmwf_pkg::win_cmd_t                   cmd_i,
  input  wire logic        [tmwf_pkg::IDX_W-1:0]    rd_idx_i,
  output logic signed      [tmwf_pkg::SAMPLE_W-1:0] rd_data_o,
  output logic             [tmwf_pkg::IDX_W-1:0]    wr_slot_o
);

  localparam logic [tmwf_pkg::IDX_W-1:0] LastSlot =
    tmwf_pkg::IDX_W'(tmwf_pkg::WINDOW_LEN - 1);

  logic signed [tmwf_pkg::SAMPLE_W-1:0] entry_q [tmwf_pkg::WINDOW_LEN];
  logic        [tmwf_pkg::IDX_W-1:0]    slot_q;
  logic        [tmwf_pkg::IDX_W-1:0]    slot_d;

  // A fill rewinds the slot; a push advances it around the ring.
  always_comb begin
    slot_d = slot_q;
    if (cmd_i.fill) begin
      slot_d = '0;
    end else if (cmd_i.push) begin
      slot_d = (slot_q == LastSlot) ? '0 : slot_q + 1'b1;
    end
  end

  // Entry storage: a fill loads every entry, a push loads the current slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      for (int i = 0; i < tmwf_pkg::WINDOW_LEN; i++) begin
        entry_q[i] <= '0;
      end
    end else begin
      slot_q <= slot_d;
      for (int i = 0; i < tmwf_pkg::WINDOW_LEN; i++) begin
        if (cmd_i.fill || (cmd_i.push && (slot_q == tmwf_pkg::IDX_W'(i)))) begin
          entry_q[i] <= cmd_i.data;
        end
      end
    end
  end

  assign rd_data_o = entry_q[rd_idx_i];
  assign wr_slot_o = slot_q;

endmodule

`default_nettype wire

// File: sv/tmwf_divider.sv
// ----------------------------------------------------------------------------
// Iterative signed divider
// Restoring division of the window sum by the entry count, two bits a step,
// with the quotient truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tmwf_divider (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire tmwf_pkg::div_req_t                   req_i,
  output logic                                      done_o,
  output logic signed      [tmwf_pkg::SAMPLE_W-1:0] quot_o
);

  localparam int CW = tmwf_pkg::CNT_W;

  logic                              busy_q;
  logic                              done_q;
  logic [tmwf_pkg::STEP_W-1:0]       cnt_q;
  logic [CW-1:0]                     rem_q;
  logic [CW-1:0]                     den_q;
  logic [tmwf_pkg::DIV_W-1:0]        mag_q;
  logic                              neg_q;

  logic [tmwf_pkg::SUM_W-1:0]        abs_val;
  logic [CW:0]                       r1;
  logic [CW:0]                       r1s;
  logic [CW:0]                       r2;
  logic [CW:0]                       r2s;
  logic                              ge1;
  logic                              ge2;
  logic [tmwf_pkg::SAMPLE_W-1:0]     q_mag;

  // Magnitude of the dividend; the sum never reaches the most negative code.
  assign abs_val = req_i.dividend[tmwf_pkg::SUM_W-1] ?
                   tmwf_pkg::SUM_W'(-req_i.dividend) :
                   tmwf_pkg::SUM_W'(req_i.dividend);

  // Two chained restoring steps on the narrow remainder.
  always_comb begin
    r1  = {rem_q, mag_q[tmwf_pkg::DIV_W-1]};
    ge1 = (r1 >= {1'b0, den_q});
    r1s = ge1 ? (r1 - {1'b0, den_q}) : r1;
    r2  = {r1s[CW-1:0], mag_q[tmwf_pkg::DIV_W-2]};
    ge2 = (r2 >= {1'b0, den_q});
    r2s = ge2 ? (r2 - {1'b0, den_q}) : r2;
  end

  // Step sequencing; quotient bits shift in at the bottom of mag_q.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= tmwf_pkg::STEP_W'(tmwf_pkg::DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == tmwf_pkg::STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mag_q <= tmwf_pkg::DIV_W'(abs_val);
      rem_q <= '0;
      den_q <= req_i.divisor;
      neg_q <= req_i.dividend[tmwf_pkg::SUM_W-1];
    end else if (busy_q) begin
      mag_q <= {mag_q[tmwf_pkg::DIV_W-3:0], ge1, ge2};
      rem_q <= r2s[CW-1:0];
    end
  end

  assign q_mag  = mag_q[tmwf_pkg::SAMPLE_W-1:0];
  assign quot_o = neg_q ? -q_mag : q_mag;
  assign done_o = done_q;

endmodule

`default_nettype wire

// File: sv/trimmed_mean_window_filter.sv
// ----------------------------------------------------------------------------
// Trimmed-mean window filter
// Moving-window filter that averages a ring of samples after dropping the
// smallest and largest entry once the window is full.
// ----------------------------------------------------------------------------
// Each item with tuser low writes its sample into the 9-entry ring and yields
// one result: the truncated mean of the filled entries, or, once all count,
// the mean without the first minimum and first maximum. An item with tuser
// high loads every entry with its sample, rewinds the write slot and yields
// nothing. From acceptance to result a sample item goes through one pass over
// the ring with the shared accumulate and compare unit, the trim state, the
// divider launch state, 14 steps of the radix-4 divider, the state in which
// the sequencer sees the divider finish, then the load of the output register,
// which waits until that register is free. The input stays not ready until
// the result is in the output register; a result waiting there does not stop
// the next item from entering.
// ----------------------------------------------------------------------------
`default_nettype none

`include "trimmed_mean_window_filter_macros.svh"

module trimmed_mean_window_filter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,   // [23:0] sample
  input  wire logic        s_axis_tuser_i,   // [0] func (1 = fill window)
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [23:0] m_axis_tdata_o    // [23:0] filtered
);

  localparam int N  = tmwf_pkg::WINDOW_LEN;
  localparam int IW = tmwf_pkg::IDX_W;
  localparam int CW = tmwf_pkg::CNT_W;
  localparam int SW = tmwf_pkg::SAMPLE_W;
  localparam int AW = tmwf_pkg::SUM_W;

  localparam logic [IW-1:0] LastIdx  = IW'(N - 1);
  localparam logic [CW-1:0] FullCnt  = CW'(N);
  localparam logic [CW-1:0] TrimOne  = CW'(N - 1);
  localparam logic [CW-1:0] TrimTwo  = CW'(N - 2);

  tmwf_pkg::state_e   state_q, state_d;
  tmwf_pkg::win_cmd_t win_cmd;
  tmwf_pkg::div_req_t div_req;

  logic [IW-1:0]        idx_q, idx_d;
  logic signed [AW-1:0] sum_q, sum_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic signed [SW-1:0] min_q, min_d;
  logic signed [SW-1:0] max_q, max_d;
  logic [IW-1:0]        lo_q, lo_d;
  logic [IW-1:0]        hi_q, hi_d;
  logic [CW-1:0]        den_q, den_d;
  logic signed [SW-1:0] out_q, out_d;
  logic                 out_vld_q, out_vld_d;

  logic signed [SW-1:0] rd_data;
  logic [IW-1:0]        wr_slot;
  logic                 counts;
  logic                 full;
  logic                 in_acc;
  logic                 div_done;
  logic signed [SW-1:0] quot;

  // Sample ring.
  tmwf_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (win_cmd),
    .rd_idx_i  (idx_q),
    .rd_data_o (rd_data),
    .wr_slot_o (wr_slot)
  );

  // Divider for the final mean.
  tmwf_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  assign s_axis_tready_o = (state_q == tmwf_pkg::ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // An entry counts when nonzero, below the write slot, or the last slot
  // while the write slot sits at zero.
  assign counts = (rd_data != '0) || (idx_q < wr_slot) ||
                  ((wr_slot == '0) && (idx_q == LastIdx));
  assign full   = (cnt_q == FullCnt);

  // Ring writes come straight from an accepted item.
  always_comb begin
    win_cmd.fill = in_acc && s_axis_tuser_i;
    win_cmd.push = in_acc && !s_axis_tuser_i;
    win_cmd.data = s_axis_tdata_i;
  end

  // Divider launch uses the trimmed sum and the entry count.
  always_comb begin
    div_req.start    = (state_q == tmwf_pkg::ST_START);
    div_req.dividend = sum_q;
    div_req.divisor  = den_q;
  end

  // Sequencer and shared accumulate/compare unit.
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    min_d     = min_q;
    max_d     = max_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    den_d     = den_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !m_axis_tready_i;

    unique case (state_q)
      tmwf_pkg::ST_IDLE: begin
        if (in_acc && !s_axis_tuser_i) begin
          idx_d   = '0;
          sum_d   = '0;
          cnt_d   = '0;
          state_d = tmwf_pkg::ST_SCAN;
        end
      end
      tmwf_pkg::ST_SCAN: begin
        if (counts) begin
          sum_d = sum_q + AW'(rd_data);
          cnt_d = cnt_q + 1'b1;
        end
        // First minimum and first maximum by strict comparison.
        if ((idx_q == '0) || (rd_data < min_q)) begin
          min_d = rd_data;
          lo_d  = idx_q;
        end
        if ((idx_q == '0) || (rd_data > max_q)) begin
          max_d = rd_data;
          hi_d  = idx_q;
        end
        if (idx_q == LastIdx) begin
          state_d = tmwf_pkg::ST_TRIM;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      tmwf_pkg::ST_TRIM: begin
        // With a full window, every entry was summed; take out the extremes.
        if (full) begin
          if (lo_q != hi_q) begin
            sum_d = sum_q - AW'(min_q) - AW'(max_q);
            den_d = TrimTwo;
          end else begin
            sum_d = sum_q - AW'(min_q);
            den_d = TrimOne;
          end
        end else begin
          den_d = cnt_q;
        end
        state_d = tmwf_pkg::ST_START;
      end
      tmwf_pkg::ST_START: begin
        state_d = tmwf_pkg::ST_DIV;
      end
      tmwf_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = tmwf_pkg::ST_OUT;
        end
      end
      tmwf_pkg::ST_OUT: begin
        // Load the result once the output register is free.
        if (!out_vld_q || m_axis_tready_i) begin
          out_d     = quot;
          out_vld_d = 1'b1;
          state_d   = tmwf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tmwf_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tmwf_pkg::ST_IDLE;
      out_vld_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      idx_q     <= idx_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    cnt_q <= cnt_d;
    min_q <= min_d;
    max_q <= max_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    den_q <= den_d;
    out_q <= out_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

  // A sample item always starts a scan at the first slot.
  `TMWF_ASSERT_NEXT(a_scan_start, in_acc && !s_axis_tuser_i,
                    (state_q == tmwf_pkg::ST_SCAN) && (idx_q == '0),
                    "sample item did not start a scan")

  // The divider is never launched with a zero count.
  `TMWF_ASSERT_SAME(a_den_nonzero, state_q == tmwf_pkg::ST_START, den_q != '0,
                    "divider launched with zero count")

  // A new result appears only when the sequencer hands one over.
  `TMWF_ASSERT_SAME(a_out_source, $rose(m_axis_tvalid_o),
                    $past(state_q == tmwf_pkg::ST_OUT),
                    "result appeared outside the output step")

  // The write slot stays inside the ring.
  `TMWF_ASSERT_SAME(a_slot_range, 1'b1, wr_slot <= LastIdx,
                    "write slot outside the ring")

endmodule

`default_nettype wire

// File: dv/trimmed_mean_window_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trimmed-mean window filter testbench
// Drives sample and fill items into the filter with bursty timing and a
// stalling receiver. A scoreboard keeps its own copy of the sample ring,
// predicts every filtered value and compares it with the block's output.
// ----------------------------------------------------------------------------

// Input item kinds, carried on the slave-side tuser bit.
typedef enum logic {
  FUNC_FILTER = 1'b0,
  FUNC_FILL   = 1'b1
} func_e;

// Scoreboard: ring model, pending filtered values and mismatch count.
class window_mean_sb;
  logic signed [tmwf_pkg::SAMPLE_W-1:0] ring [tmwf_pkg::WINDOW_LEN];
  logic        [tmwf_pkg::IDX_W-1:0]    slot;
  logic        [tmwf_pkg::SAMPLE_W-1:0] expected_means [$];
  int                                   mismatches;
  int                                   checked;

  function new();
    foreach (ring[i]) ring[i] = '0;
    slot       = '0;
    mismatches = 0;
    checked    = 0;
  endfunction

  // An entry takes part in the partial mean if it holds data, lies below the
  // write slot, or is the last slot right after the slot wrapped.
  function bit entry_counts(int i);
    return ring[i] != 0 || i < slot ||
           (slot == 0 && i == tmwf_pkg::WINDOW_LEN - 1);
  endfunction

  // Updates the ring for an accepted item and queues the value it must yield.
  function void note_sample(logic func, logic signed [tmwf_pkg::SAMPLE_W-1:0] sample);
    logic signed [tmwf_pkg::SUM_W-1:0] sum;
    int                                cnt;
    int                                lo;
    int                                hi;
    if (func == FUNC_FILL) begin
      foreach (ring[i]) ring[i] = sample;
      slot = '0;
      return;
    end
    ring[slot] = sample;
    slot = (slot == tmwf_pkg::WINDOW_LEN - 1) ? '0 : slot + 1'b1;

    cnt = 0;
    foreach (ring[i]) if (entry_counts(i)) cnt++;

    sum = '0;
    if (cnt < tmwf_pkg::WINDOW_LEN) begin
      // Partial window: plain mean of the counted entries.
      cnt = 0;
      foreach (ring[i]) begin
        if (entry_counts(i)) begin
          sum += ring[i];
          cnt++;
        end
      end
    end else begin
      // Full window: drop the lowest-slot minimum and maximum.
      lo = 0;
      hi = 0;
      for (int i = 1; i < tmwf_pkg::WINDOW_LEN; i++) begin
        if (ring[i] < ring[lo]) lo = i;
        if (ring[i] > ring[hi]) hi = i;
      end
      cnt = 0;
      foreach (ring[i]) begin
        if (i != lo && i != hi) begin
          sum += ring[i];
          cnt++;
        end
      end
    end
    // Signed division truncates toward zero.
    expected_means.push_back(tmwf_pkg::SAMPLE_W'(sum / cnt));
  endfunction

  // Compares one output item with the oldest pending value.
  function void check_filtered(logic [tmwf_pkg::SAMPLE_W-1:0] actual);
    logic [tmwf_pkg::SAMPLE_W-1:0] want;
    if (expected_means.size() == 0) begin
      $display("%0t: unexpected filtered item: expected none, actual %0d",
               $time, $signed(actual));
      mismatches++;
      return;
    end
    want = expected_means.pop_front();
    checked++;
    if (actual !== want) begin
      $display("%0t: filtered mismatch: expected %0d, actual %0d",
               $time, $signed(want), $signed(actual));
      mismatches++;
    end
  endfunction
endclass

module trimmed_mean_window_filter_tb;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 600;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 200;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [23:0] s_tdata  = '0;
  logic        s_tuser  = FUNC_FILTER;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [23:0] m_axis_tdata_o;

  window_mean_sb sb = new();

  int cycle_count = 0;
  int n_filter    = 0;
  int n_fill      = 0;
  int burst_left  = 0;
  bit hold_done   = 1'b0;

  trimmed_mean_window_filter i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run-length guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d filtered values still pending",
               $time, cycle_count, sb.expected_means.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Monitor both handshakes on the pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid && s_axis_tready_o) begin
      sb.note_sample(s_tuser, s_tdata);
      if (s_tuser == FUNC_FILL) n_fill++;
      else n_filter++;
    end
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      sb.check_filtered(m_axis_tdata_o);
    end
  end

  // Receiver: stall patterns in runs, plus one long hold-off that backs the
  // block up into its input.
  initial begin : receiver
    int mode;
    int run;
    wait (rst_ni);
    forever begin
      if (!hold_done && n_filter >= HOLD_AFTER) begin
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(posedge clk_i);
          m_tready <= 1'b0;
        end
      end
      mode = $urandom_range(0, 3);
      run  = $urandom_range(10, 80);
      repeat (run) begin
        @(posedge clk_i);
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 7) != 0);
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offers one item and waits for its handshake; ends a burst, mostly with a gap.
  task automatic offer(input logic func, input logic [23:0] sample);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= sample;
    do @(posedge clk_i); while (!s_axis_tready_o);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Sample mix: wide random values, small values for ties and zeros, extremes.
  function automatic logic [23:0] pick_sample();
    logic [23:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = 24'($urandom);
      4, 5:       v = 24'(int'($urandom_range(0, 8)) - 4);
      6:          v = '0;
      7:          v = 24'h7FFFFF;
      8:          v = 24'h800000;
      default:    v = ($urandom_range(0, 1) ? 24'h7FFFF0 : 24'h800000) +
                      24'($urandom_range(0, 15));
    endcase
    return v;
  endfunction

  initial begin : stimulus
    int sent;
    int run;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: partial window from reset with extremes and negative
    // truncation, wrap of the write slot, full-window trimming.
    offer(FUNC_FILTER, 24'd0);
    offer(FUNC_FILTER, 24'h800000);
    offer(FUNC_FILTER, 24'h7FFFFF);
    offer(FUNC_FILTER, 24'hFFFFFF);
    offer(FUNC_FILTER, -24'sd4);
    offer(FUNC_FILTER, 24'd3);
    offer(FUNC_FILTER, 24'd0);
    offer(FUNC_FILTER, 24'd7);
    offer(FUNC_FILTER, 24'd1);
    offer(FUNC_FILTER, 24'h800000);
    // Equal entries: minimum and maximum fall on one slot.
    offer(FUNC_FILL,   24'd5);
    offer(FUNC_FILTER, 24'd5);
    offer(FUNC_FILTER, 24'd5);
    // Zero fill: zero entries above the write slot do not count.
    offer(FUNC_FILL,   24'd0);
    offer(FUNC_FILTER, 24'd0);
    offer(FUNC_FILTER, -24'sd7);
    // Extreme fills with opposite samples.
    offer(FUNC_FILL,   24'h7FFFFF);
    offer(FUNC_FILTER, 24'h800000);
    offer(FUNC_FILTER, 24'h7FFFFF);
    offer(FUNC_FILL,   24'h800000);
    offer(FUNC_FILTER, 24'h800000);
    offer(FUNC_FILTER, 24'd123456);
    offer(FUNC_FILTER, -24'sd123457);
    offer(FUNC_FILL,   24'hFFFFFF);
    offer(FUNC_FILTER, 24'd2);

    // Random: runs of samples, each preceded by a window fill half of the time.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 1) == 0) begin
        offer(FUNC_FILL, ($urandom_range(0, 3) == 0) ? 24'd0 : pick_sample());
        sent++;
      end
      run = $urandom_range(1, 30);
      repeat (run) begin
        offer(FUNC_FILTER, pick_sample());
        sent++;
      end
    end
    s_tvalid <= 1'b0;
    // Let the monitor record the last accepted item before draining.
    @(posedge clk_i);

    // Drain, then allow for the block's latency.
    while (sb.expected_means.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d sample items and %0d fill items; %0d filtered values checked.",
             n_filter, n_fill, sb.checked);
    $display("Receiver long hold-off applied: %0d.", hold_done);
    if (sb.mismatches == 0 && sb.expected_means.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
